// ===== design/tbit_pkg.sv =====
`timescale 1ns / 1ps
// tbit_pkg: shared widths, operation codes and helpers for the time/beat tracker.
// Used by tbit_scale and time_beat_interpolating_tracker_core. No dependencies.
package tbit_pkg;

  // Signed fixed-point word (Q31.16). The fraction point never enters the
  // arithmetic: the proportional step is a ratio, so the fraction bits cancel.
  localparam int W     = 48;
  localparam int CNT_W = $clog2(W);

  typedef enum logic [3:0] {
    OP_LOAD        = 4'd0,
    OP_ADD_OFS     = 4'd1,
    OP_SET_OFS     = 4'd2,
    OP_SET_TARGET  = 4'd3,
    OP_BY_TIME     = 4'd4,
    OP_BY_BEAT     = 4'd5,
    OP_ALL         = 4'd6,
    OP_SPLIT_TIME  = 4'd7,
    OP_SPLIT_BEAT  = 4'd8
  } tbit_op_t;

  // x + y or x - y, saturated to the signed W-bit range
  function automatic logic signed [W-1:0] sat_sum(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y,
                                                  input logic sub);
    logic [W:0] s;
    s = sub ? ({x[W-1], x} - {y[W-1], y}) : ({x[W-1], x} + {y[W-1], y});
    if (s[W] != s[W-1]) begin
      sat_sum = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      sat_sum = s[W-1:0];
    end
  endfunction

  // absolute value; the most negative word maps to 2^(W-1), which fits unsigned
  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    mag = x[W-1] ? ({W{1'b0}} - x) : x;
  endfunction

endpackage

// ===== design/tbit_scale.sv =====
`timescale 1ns / 1ps
// tbit_scale: bit-serial num * mul / den, truncated toward zero and saturated.
// Shift-add multiply then restoring divide, one bit per cycle. Depends on tbit_pkg.
module tbit_scale import tbit_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] mul,
  input  logic signed [W-1:0] den,
  output logic                done,
  output logic signed [W-1:0] quot
);

  typedef enum logic [2:0] {SC_IDLE, SC_MUL, SC_CHK, SC_DIV, SC_FIN} sc_state_t;

  sc_state_t          st_r, st_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]       mag_a_r, mag_a_nxt;
  logic [W-1:0]       mag_d_r, mag_d_nxt;
  logic [2*W-1:0]     acc_r, acc_nxt;     // product, then remainder:quotient
  logic               neg_r, neg_nxt;
  logic               ovf_r, ovf_nxt;
  logic               done_r, done_nxt;
  logic signed [W-1:0] quot_r, quot_nxt;

  logic [W:0]   add_sum;
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] q_raw;
  logic [W-1:0] half;
  logic [W-1:0] m_neg;
  logic         last;

  assign add_sum = {1'b0, acc_r[2*W-1:W]} + {1'b0, mag_a_r};
  assign trial   = acc_r[2*W-1:W-1];
  assign diff    = trial - {1'b0, mag_d_r};
  assign fits    = trial >= {1'b0, mag_d_r};
  assign q_raw   = acc_r[W-1:0];
  assign half    = {1'b1, {(W-1){1'b0}}};
  assign m_neg   = (ovf_r || (q_raw > half)) ? half : q_raw;
  assign last    = cnt_r == CNT_W'(W - 1);

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    mag_a_nxt = mag_a_r;
    mag_d_nxt = mag_d_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    quot_nxt  = quot_r;
    case (st_r)
      SC_IDLE: begin
        if (start) begin
          mag_a_nxt = mag(num);
          mag_d_nxt = mag(den);
          acc_nxt   = {{W{1'b0}}, mag(mul)};
          neg_nxt   = num[W-1] ^ mul[W-1] ^ den[W-1];
          cnt_nxt   = '0;
          st_nxt    = SC_MUL;
        end
      end
      SC_MUL: begin
        acc_nxt = acc_r[0] ? {add_sum, acc_r[W-1:1]} : {1'b0, acc_r[2*W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt = '0;
          st_nxt  = SC_CHK;
        end
      end
      SC_CHK: begin
        // upper half not below the divisor: quotient reaches 2^W, saturate
        ovf_nxt = acc_r[2*W-1:W] >= mag_d_r;
        st_nxt  = SC_DIV;
      end
      SC_DIV: begin
        acc_nxt = {(fits ? diff[W-1:0] : trial[W-1:0]), acc_r[W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt = '0;
          st_nxt  = SC_FIN;
        end
      end
      SC_FIN: begin
        if (neg_r) begin
          quot_nxt = {W{1'b0}} - m_neg;
        end else begin
          quot_nxt = (ovf_r || q_raw[W-1]) ? {1'b0, {(W-1){1'b1}}} : q_raw;
        end
        done_nxt = 1'b1;
        st_nxt   = SC_IDLE;
      end
      default: st_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SC_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    mag_a_r <= mag_a_nxt;
    mag_d_r <= mag_d_nxt;
    acc_r   <= acc_nxt;
    neg_r   <= neg_nxt;
    ovf_r   <= ovf_nxt;
    quot_r  <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== design/time_beat_interpolating_tracker_core.sv =====
`timescale 1ns / 1ps
// Time/beat interpolating tracker. Depends on tbit_pkg and tbit_scale.
// Ops that need no proportional step pass IDLE, EXEC and POST; a proportional step adds
// SCALE, which waits for the multiply and divide bit steps of tbit_scale.
// One item in flight at a time; a new transfer waits until the current item is done.
// Next transfer is taken the cycle after the result loads.
// Reset (synchronous, rst_n low): position and pending segment cleared to zero, no result.
module time_beat_interpolating_tracker_core import tbit_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_op,
  input  logic signed [W-1:0] in_time_value,
  input  logic signed [W-1:0] in_beat_value,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [W-1:0] out_time,
  output logic signed [W-1:0] out_beat,
  output logic signed [W-1:0] out_delta_time,
  output logic signed [W-1:0] out_delta_beat
);

  // IDLE takes a transfer, EXEC does the ops that need no proportional step or
  // launches the scaler, SCALE waits for it, POST hands the result to the output register.
  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCALE, ST_POST} state_t;

  state_t state_r, state_nxt;

  // captured operands
  logic [3:0]          op_r, op_nxt;
  logic signed [W-1:0] tv_r, tv_nxt;
  logic signed [W-1:0] bv_r, bv_nxt;

  // architectural state
  logic signed [W-1:0] pos_t_r, pos_t_nxt;
  logic signed [W-1:0] pos_b_r, pos_b_nxt;
  logic signed [W-1:0] pend_t_r, pend_t_nxt;
  logic signed [W-1:0] pend_b_r, pend_b_nxt;

  // split preview result (time axis, beat axis)
  logic signed [W-1:0] od_t_r, od_t_nxt;
  logic signed [W-1:0] od_b_r, od_b_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic signed [W-1:0] out_time_r, out_time_nxt;
  logic signed [W-1:0] out_beat_r, out_beat_nxt;
  logic signed [W-1:0] out_dt_r, out_dt_nxt;
  logic signed [W-1:0] out_db_r, out_db_nxt;

  // Stepping-axis view: "a" is the axis the operand moves along, "b" the
  // other one. Ops on the beat axis just swap the roles.
  logic                beat_axis;
  logic                is_split;
  logic signed [W-1:0] step, da, db, pa, pb;
  logic                step_ge, da_zero, db_zero;
  logic signed [W-1:0] pa_n, pb_n, da_n, db_n, ra_n, rb_n;
  logic                adv_wr, split_wr;

  logic                sc_start;
  logic                sc_done;
  logic signed [W-1:0] sc_q;

  assign beat_axis = (op_r == OP_BY_BEAT) || (op_r == OP_SPLIT_BEAT);
  assign is_split  = (op_r == OP_SPLIT_TIME) || (op_r == OP_SPLIT_BEAT);
  assign step      = beat_axis ? bv_r : tv_r;
  assign da        = beat_axis ? pend_b_r : pend_t_r;
  assign db        = beat_axis ? pend_t_r : pend_b_r;
  assign pa        = beat_axis ? pos_b_r : pos_t_r;
  assign pb        = beat_axis ? pos_t_r : pos_b_r;
  assign step_ge   = step >= da;
  assign da_zero   = da == '0;
  assign db_zero   = db == '0;

  // other-axis share of a partial step: db * step / da
  tbit_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sc_start),
    .num   (db),
    .mul   (step),
    .den   (da),
    .done  (sc_done),
    .quot  (sc_q)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tv_nxt        = tv_r;
    bv_nxt        = bv_r;
    pos_t_nxt     = pos_t_r;
    pos_b_nxt     = pos_b_r;
    pend_t_nxt    = pend_t_r;
    pend_b_nxt    = pend_b_r;
    od_t_nxt      = od_t_r;
    od_b_nxt      = od_b_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_time_nxt  = out_time_r;
    out_beat_nxt  = out_beat_r;
    out_dt_nxt    = out_dt_r;
    out_db_nxt    = out_db_r;
    pa_n          = pa;
    pb_n          = pb;
    da_n          = da;
    db_n          = db;
    ra_n          = da;
    rb_n          = db;
    adv_wr        = 1'b0;
    split_wr      = 1'b0;
    sc_start      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          tv_nxt    = in_time_value;
          bv_nxt    = in_beat_value;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_POST;
        case (op_r)
          OP_LOAD: begin
            pos_t_nxt  = tv_r;
            pos_b_nxt  = bv_r;
            pend_t_nxt = '0;
            pend_b_nxt = '0;
          end
          OP_ADD_OFS: begin
            pend_t_nxt = sat_sum(pend_t_r, tv_r, 1'b0);
            pend_b_nxt = sat_sum(pend_b_r, bv_r, 1'b0);
          end
          OP_SET_OFS: begin
            pend_t_nxt = tv_r;
            pend_b_nxt = bv_r;
          end
          OP_SET_TARGET: begin
            pend_t_nxt = sat_sum(tv_r, pos_t_r, 1'b1);
            pend_b_nxt = sat_sum(bv_r, pos_b_r, 1'b1);
          end
          OP_BY_TIME, OP_BY_BEAT: begin
            if (da_zero) begin
              // flat on the stepping axis: the other axis jumps whole
              if (!db_zero) begin
                pb_n   = sat_sum(pb, db, 1'b0);
                db_n   = '0;
                adv_wr = 1'b1;
              end
            end else if (step_ge) begin
              // at or past the end: finish the segment exactly
              pa_n   = sat_sum(pa, da, 1'b0);
              pb_n   = sat_sum(pb, db, 1'b0);
              da_n   = '0;
              db_n   = '0;
              adv_wr = 1'b1;
            end else begin
              sc_start  = 1'b1;
              state_nxt = ST_SCALE;
            end
          end
          OP_ALL: begin
            pos_t_nxt  = sat_sum(pos_t_r, pend_t_r, 1'b0);
            pos_b_nxt  = sat_sum(pos_b_r, pend_b_r, 1'b0);
            pend_t_nxt = '0;
            pend_b_nxt = '0;
          end
          OP_SPLIT_TIME, OP_SPLIT_BEAT: begin
            if (step_ge) begin
              ra_n     = da;
              rb_n     = db;
              split_wr = 1'b1;
            end else if (da_zero) begin
              // negative offset below a flat segment
              ra_n     = step;
              rb_n     = '0;
              split_wr = 1'b1;
            end else begin
              sc_start  = 1'b1;
              state_nxt = ST_SCALE;
            end
          end
          default: ;
        endcase
      end

      ST_SCALE: begin
        if (sc_done) begin
          state_nxt = ST_POST;
          if (is_split) begin
            ra_n     = step;
            rb_n     = sc_q;
            split_wr = 1'b1;
          end else begin
            pa_n   = sat_sum(pa, step, 1'b0);
            pb_n   = sat_sum(pb, sc_q, 1'b0);
            da_n   = sat_sum(da, step, 1'b1);
            db_n   = sat_sum(db, sc_q, 1'b1);
            adv_wr = 1'b1;
          end
        end
      end

      ST_POST: begin
        // output register free or emptied by a transfer this cycle
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = pos_t_r;
          out_beat_nxt  = pos_b_r;
          out_dt_nxt    = is_split ? od_t_r : pend_t_r;
          out_db_nxt    = is_split ? od_b_r : pend_b_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // map the stepping-axis view back onto time and beat
    if (adv_wr) begin
      if (beat_axis) begin
        pos_b_nxt  = pa_n;
        pos_t_nxt  = pb_n;
        pend_b_nxt = da_n;
        pend_t_nxt = db_n;
      end else begin
        pos_t_nxt  = pa_n;
        pos_b_nxt  = pb_n;
        pend_t_nxt = da_n;
        pend_b_nxt = db_n;
      end
    end
    if (split_wr) begin
      od_t_nxt = beat_axis ? rb_n : ra_n;
      od_b_nxt = beat_axis ? ra_n : rb_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_t_r     <= '0;
      pos_b_r     <= '0;
      pend_t_r    <= '0;
      pend_b_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_t_r     <= pos_t_nxt;
      pos_b_r     <= pos_b_nxt;
      pend_t_r    <= pend_t_nxt;
      pend_b_r    <= pend_b_nxt;
    end
    op_r       <= op_nxt;
    tv_r       <= tv_nxt;
    bv_r       <= bv_nxt;
    od_t_r     <= od_t_nxt;
    od_b_r     <= od_b_nxt;
    out_time_r <= out_time_nxt;
    out_beat_r <= out_beat_nxt;
    out_dt_r   <= out_dt_nxt;
    out_db_r   <= out_db_nxt;
  end

  // a new transfer is taken only between items
  assign in_stall       = state_r != ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_time       = out_time_r;
  assign out_beat       = out_beat_r;
  assign out_delta_time = out_dt_r;
  assign out_delta_beat = out_db_r;

endmodule

// ===== verif/tb_time_beat_interpolating_tracker_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for time_beat_interpolating_tracker_core.
// Depends on tbit_pkg and the tracker RTL; runs a directed table, then constrained-free
// random traffic with idle bursts on both channels, checked against a local predictor.
module tb_time_beat_interpolating_tracker_core;
  import tbit_pkg::*;

  // ---------------------------------------------------------------------------
  // Types and constants
  // ---------------------------------------------------------------------------
  typedef logic signed [W-1:0] word_t;
  typedef logic [2*W-1:0]      wide_t;   // holds a full 48x48 magnitude product

  typedef struct packed {
    word_t pos_t;
    word_t pos_b;
    word_t seg_t;
    word_t seg_b;
  } trk_result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [3:0]  op;
    word_t       tv;
    word_t       bv;
    logic        typed;
    trk_result_t res;
  } dir_row_t;

  localparam word_t       VMAX     = {1'b0, {(W-1){1'b1}}};
  localparam word_t       VMIN     = {1'b1, {(W-1){1'b0}}};
  localparam word_t       ZERO     = '0;
  localparam word_t       NEG1     = '1;
  localparam int          FRAC     = 16;
  localparam logic [3:0]  OP_NONE_FIRST = 4'd9;   // codes 9..15 leave state alone
  localparam logic [3:0]  OP_NONE_LAST  = 4'd15;
  localparam trk_result_t NO_RES   = '0;
  localparam int          DIR_N    = 25;
  localparam int          RAND_N   = 1200;
  localparam int          QUIET_N  = 150;   // final stretch with no idling at all
  localparam int          HOLD_AT  = 150;   // result count that triggers the long hold
  localparam int          HOLD_LEN = 300;
  localparam int          DRAIN    = 120;   // > worst-case latency of a proportional step

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  [3:0] in_op = '0;
  word_t in_time_value = '0;
  word_t in_beat_value = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_time;
  word_t out_beat;
  word_t out_delta_time;
  word_t out_delta_beat;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  time_beat_interpolating_tracker_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_time_value  (in_time_value),
    .in_beat_value  (in_beat_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_time       (out_time),
    .out_beat       (out_beat),
    .out_delta_time (out_delta_time),
    .out_delta_beat (out_delta_beat)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: current position and pending segment
  // ---------------------------------------------------------------------------
  word_t pos_time = '0;
  word_t pos_beat = '0;
  word_t seg_time = '0;
  word_t seg_beat = '0;

  trk_result_t expected_track_q[$];
  int unsigned errors = 0;
  bit          quiet = 1'b0;   // set for the last part of the run: no gaps, no stalls
  int unsigned gap_pct = 0;

  // clamp a wide sum back into the signed word range
  function automatic word_t sat_w(longint x);
    if (x > longint'(VMAX)) return VMAX;
    if (x < longint'(VMIN)) return VMIN;
    return word_t'(x);
  endfunction

  function automatic word_t q16(int x);
    return word_t'(longint'(x) <<< FRAC);
  endfunction

  // n * s / d, truncated toward zero, saturated; d is never zero here
  function automatic word_t ratio_step(word_t n, word_t s, word_t d);
    logic  neg;
    wide_t mn, ms, md, quo, cap;
    neg = n[W-1] ^ s[W-1] ^ d[W-1];
    mn  = wide_t'(n[W-1] ? -longint'(n) : longint'(n));
    ms  = wide_t'(s[W-1] ? -longint'(s) : longint'(s));
    md  = wide_t'(d[W-1] ? -longint'(d) : longint'(d));
    quo = (mn * ms) / md;
    cap = neg ? (wide_t'(1) << (W-1)) : (wide_t'(1) << (W-1)) - 1;
    if (quo > cap) quo = cap;
    return neg ? word_t'(-longint'(quo[63:0])) : word_t'(quo[W-1:0]);
  endfunction

  // move along the segment by step on axis a; axis b follows in proportion
  task automatic seg_advance(input word_t step, inout word_t da, inout word_t db,
                             inout word_t pa, inout word_t pb);
    word_t sa, sb;
    if (da == ZERO) begin
      if (db == ZERO) return;
      sa = ZERO;
      sb = db;
      db = ZERO;
    end else if (step >= da) begin
      sa = da;
      sb = db;
      da = ZERO;
      db = ZERO;
    end else begin
      sa = step;
      sb = ratio_step(db, step, da);
      da = sat_w(longint'(da) - longint'(sa));
      db = sat_w(longint'(db) - longint'(sb));
    end
    pa = sat_w(longint'(pa) + longint'(sa));
    pb = sat_w(longint'(pb) + longint'(sb));
  endtask

  task automatic seg_split(input word_t off, input word_t da, input word_t db,
                           output word_t ra, output word_t rb);
    if (off >= da) begin
      ra = da;
      rb = db;
    end else if (da == ZERO) begin
      ra = off;
      rb = ZERO;
    end else begin
      ra = off;
      rb = ratio_step(db, off, da);
    end
  endtask

  task automatic track_predict(input logic [3:0] op, input word_t tv, input word_t bv,
                               output trk_result_t r);
    word_t odt, odb;
    case (op)
      OP_LOAD: begin
        pos_time = tv;
        pos_beat = bv;
        seg_time = ZERO;
        seg_beat = ZERO;
      end
      OP_ADD_OFS: begin
        seg_time = sat_w(longint'(seg_time) + longint'(tv));
        seg_beat = sat_w(longint'(seg_beat) + longint'(bv));
      end
      OP_SET_OFS: begin
        seg_time = tv;
        seg_beat = bv;
      end
      OP_SET_TARGET: begin
        seg_time = sat_w(longint'(tv) - longint'(pos_time));
        seg_beat = sat_w(longint'(bv) - longint'(pos_beat));
      end
      OP_BY_TIME: seg_advance(tv, seg_time, seg_beat, pos_time, pos_beat);
      OP_BY_BEAT: seg_advance(bv, seg_beat, seg_time, pos_beat, pos_time);
      OP_ALL: begin
        pos_time = sat_w(longint'(pos_time) + longint'(seg_time));
        pos_beat = sat_w(longint'(pos_beat) + longint'(seg_beat));
        seg_time = ZERO;
        seg_beat = ZERO;
      end
      default: ;
    endcase
    odt = seg_time;
    odb = seg_beat;
    if (op == OP_SPLIT_TIME) seg_split(tv, seg_time, seg_beat, odt, odb);
    else if (op == OP_SPLIT_BEAT) seg_split(bv, seg_beat, seg_time, odb, odt);
    r = '{pos_time, pos_beat, odt, odb};
  endtask

  // operand generator: full random, extremes, small Q16 values, or a share of span
  // (a share of the pending delta keeps most steps strictly inside the segment)
  function automatic word_t pick_value(word_t span);
    longint v;
    case ($urandom_range(0, 9))
      0: v = longint'(word_t'({$urandom, $urandom}));
      1: begin
        case ($urandom_range(0, 4))
          0:       v = longint'(VMAX);
          1:       v = longint'(VMIN);
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      2, 3, 4: v = longint'($urandom_range(0, 2000 * 65536)) - longint'(1000 * 65536);
      default: v = longint'(span) * longint'($urandom_range(0, 120)) / 100;
    endcase
    return word_t'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one item, wait for the transfer, record what it should give
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [3:0] op, input word_t tv, input word_t bv,
                           input logic typed, input trk_result_t typed_res);
    trk_result_t r;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_time_value <= tv;
    in_beat_value <= bv;
    do @(posedge clk); while (in_stall);
    track_predict(op, tv, bv, r);
    expected_track_q.push_back(typed ? typed_res : r);
  endtask

  dir_row_t dir_tab [DIR_N];

  initial begin
    logic [3:0] op;
    word_t      tv, bv;
    int unsigned pick;

    // Directed table. Typed rows: idle ops after reset, loads, a target and segment finishes
    // at the range extremes, then a Q16 load and offset. The rest follow the predictor.
    dir_tab = '{
      '{OP_NONE_FIRST, q16(5), q16(-5), 1'b1, '{ZERO, ZERO, ZERO, ZERO}},
      '{OP_NONE_LAST, VMAX, VMIN, 1'b1, '{ZERO, ZERO, ZERO, ZERO}},
      '{OP_LOAD, VMAX, VMIN, 1'b1, '{VMAX, VMIN, ZERO, ZERO}},
      '{OP_ALL, ZERO, ZERO, 1'b1, '{VMAX, VMIN, ZERO, ZERO}},
      '{OP_SET_TARGET, VMIN, VMAX, 1'b1, '{VMAX, VMIN, VMIN, VMAX}},
      '{OP_ALL, ZERO, ZERO, 1'b1, '{NEG1, NEG1, ZERO, ZERO}},
      '{OP_LOAD, q16(10), q16(20), 1'b1, '{q16(10), q16(20), ZERO, ZERO}},
      '{OP_SET_OFS, q16(100), q16(50), 1'b1, '{q16(10), q16(20), q16(100), q16(50)}},
      // partial step by time, then previews inside, below and past the segment
      '{OP_BY_TIME, q16(30), ZERO, 1'b0, NO_RES},
      '{OP_SPLIT_TIME, q16(7), VMAX, 1'b0, NO_RES},
      '{OP_SPLIT_BEAT, VMIN, q16(-3), 1'b0, NO_RES},
      '{OP_SPLIT_TIME, VMAX, ZERO, 1'b0, NO_RES},
      // step past the end finishes the segment exactly
      '{OP_BY_BEAT, ZERO, VMAX, 1'b0, NO_RES},
      // zero delta on the stepping axis: beat jumps, then nothing left to do
      '{OP_SET_OFS, ZERO, q16(7), 1'b0, NO_RES},
      '{OP_BY_TIME, q16(2), ZERO, 1'b0, NO_RES},
      '{OP_BY_TIME, q16(2), ZERO, 1'b0, NO_RES},
      // split below a zero delta gives the offset itself and zero
      '{OP_SPLIT_TIME, q16(-5), ZERO, 1'b0, NO_RES},
      // offset sums saturate
      '{OP_ADD_OFS, VMAX, VMIN, 1'b0, NO_RES},
      '{OP_ADD_OFS, VMAX, VMIN, 1'b0, NO_RES},
      // quotient saturation: tiny time delta against a full-scale beat delta
      '{OP_SET_OFS, word_t'(1), VMAX, 1'b0, NO_RES},
      '{OP_BY_TIME, VMIN, ZERO, 1'b0, NO_RES},
      // zero beat delta: negative beat split, then a beat step makes time jump
      '{OP_SET_OFS, q16(4), ZERO, 1'b0, NO_RES},
      '{OP_SPLIT_BEAT, ZERO, q16(-1), 1'b0, NO_RES},
      '{OP_BY_BEAT, ZERO, q16(1), 1'b0, NO_RES},
      '{OP_LOAD, VMIN, VMAX, 1'b1, '{VMIN, VMAX, ZERO, ZERO}}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 30;
    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_tab[i].op, dir_tab[i].tv, dir_tab[i].bv, dir_tab[i].typed,
                dir_tab[i].res);
    end

    for (int i = 0; i < RAND_N; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      quiet = (i >= RAND_N - QUIET_N);
      pick  = $urandom_range(0, 99);
      tv    = word_t'({$urandom, $urandom});
      bv    = word_t'({$urandom, $urandom});
      if (pick < 5) begin
        op = OP_LOAD;
        tv = pick_value(pos_time);
        bv = pick_value(pos_beat);
      end else if (pick < 11) begin
        op = OP_SET_TARGET;
        tv = pick_value(pos_time);
        bv = pick_value(pos_beat);
      end else if (pick < 19) begin
        op = OP_SET_OFS;
        tv = pick_value(seg_time);
        bv = pick_value(seg_beat);
      end else if (pick < 24) begin
        op = OP_ADD_OFS;
        tv = pick_value(seg_time);
        bv = pick_value(seg_beat);
      end else if (pick < 44) begin
        op = OP_BY_TIME;
        tv = pick_value(seg_time);
      end else if (pick < 64) begin
        op = OP_BY_BEAT;
        bv = pick_value(seg_beat);
      end else if (pick < 69) begin
        op = OP_ALL;
      end else if (pick < 80) begin
        op = OP_SPLIT_TIME;
        tv = pick_value(seg_time);
      end else if (pick < 91) begin
        op = OP_SPLIT_BEAT;
        bv = pick_value(seg_beat);
      end else if (pick < 96) begin
        op = 4'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST));
      end else begin
        op = OP_LOAD;
      end
      send_item(op, tv, bv, 1'b0, NO_RES);
    end
    in_valid <= 1'b0;

    // drain: every expectation met, then a latency's worth of cycles for strays
    while (expected_track_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, one long hold to back the block up,
  // and field-by-field comparison against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned burst_left;
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned seen;
    int unsigned cyc;
    bit          held;
    trk_result_t e;
    burst_left = 0;
    hold_left  = 0;
    stall_pct  = 10;
    seen       = 0;
    cyc        = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_valid && !out_stall) begin
        seen++;
        if (expected_track_q.size() == 0) begin
          $error("unexpected result transfer: time %0d beat %0d", out_time, out_beat);
          errors++;
        end else begin
          e = expected_track_q.pop_front();
          if (out_time !== e.pos_t) begin
            $error("out_time: expected %0d, actual %0d", e.pos_t, out_time);
            errors++;
          end
          if (out_beat !== e.pos_b) begin
            $error("out_beat: expected %0d, actual %0d", e.pos_b, out_beat);
            errors++;
          end
          if (out_delta_time !== e.seg_t) begin
            $error("out_delta_time: expected %0d, actual %0d", e.seg_t, out_delta_time);
            errors++;
          end
          if (out_delta_beat !== e.seg_b) begin
            $error("out_delta_beat: expected %0d, actual %0d", e.seg_b, out_delta_beat);
            errors++;
          end
        end
      end
      if (cyc % 128 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 20;
        endcase
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && seen >= HOLD_AT) begin
        // long hold while the sender keeps offering: input side must back up
        held      = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (!quiet && burst_left != 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        burst_left = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    #1500000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
